@@ design/sliding_window_label_vote_assert.svh @@
// assertion macros of the label vote design, used by the sequencer
`ifndef SLIDING_WINDOW_LABEL_VOTE_ASSERT_SVH
`define SLIDING_WINDOW_LABEL_VOTE_ASSERT_SVH

// property must hold at every rising clock edge outside reset
`define SWLV_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("swlv assertion failed");

// condition must never be seen at a rising clock edge outside reset
`define SWLV_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("swlv forbidden condition seen");

`endif

@@ design/swlv_pkg.sv @@
// shared constants and types of the sliding window label vote
`timescale 1ns / 1ps
`default_nettype none

package swlv_pkg;

  localparam int unsigned NUM_CLASSES_DEF   = 90;
  localparam int unsigned HISTORY_DEPTH_DEF = 32;

  localparam int unsigned CLASS_W    = 7;
  localparam int unsigned RANK_W     = 7;
  localparam int unsigned WIN_W      = 6;
  localparam int unsigned WARM_W     = 5;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [WIN_W-1:0]  WINDOW_LIMIT_RST = 6'd30;
  localparam logic [WARM_W-1:0] WARMUP_LIMIT_RST = 5'd5;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LIMIT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_WARMUP_LIMIT = 1'b1;

  // item kinds
  localparam logic FUNC_LABEL = 1'b0;
  localparam logic FUNC_EMPTY = 1'b1;

  // broadcast from the sequencer to every class cell
  typedef struct packed {
    logic               inc_en;
    logic [CLASS_W-1:0] inc_class;
    logic               dec_en;
    logic [CLASS_W-1:0] dec_class;
    logic               seen_en;
    logic [CLASS_W-1:0] seen_class;
    logic [RANK_W-1:0]  seen_rank;
  } cnt_upd_t;

endpackage

`default_nettype wire

@@ design/sliding_window_label_vote.sv @@
// top level of the sliding window label vote: sequencer and row of class cells
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid_i/tready_o     tdata: detected class, tuser: func
//  m_axis   out  m_axis_tvalid_o/tready_i     tdata: voted_class, tuser: has_label
//  cfg      in   cfg_we_i (no wait)           cfg_addr_i selects, cfg_wdata_i
//
//  one item at a time; a voting detection gets its result from the vote token
//  walking the class cell row, which starts once the history has been updated
//  empty frames, warm-up and out-of-range detections finish without a vote
//  reset clears counts, first-seen marks and the history pointers at once
//  a result waits in the output register until taken; no new item meanwhile
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_label_vote #(
  parameter int unsigned NUM_CLASSES   = swlv_pkg::NUM_CLASSES_DEF,
  parameter int unsigned HISTORY_DEPTH = swlv_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // register writes
  input  wire logic                            cfg_we_i,
  input  wire logic [swlv_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [swlv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // detection items
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [7:0]                      s_axis_tdata_i,  // [6:0] detected class, [7] zero
  input  wire logic [0:0]                      s_axis_tuser_i,  // [0] func
  // voted labels
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [7:0]                           m_axis_tdata_o,  // [6:0] voted_class, [7] zero
  output logic [0:0]                           m_axis_tuser_o   // [0] has_label
);

  import swlv_pkg::*;

  // count holds up to the ring depth, rank a first-seen position below the class count
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned RNK_W = $clog2(NUM_CLASSES);

  cnt_upd_t               upd;
  logic                   vote_start;
  logic                   fresh_any;
  logic                   has_label;
  logic [CLASS_W-1:0]     voted_class;
  logic [NUM_CLASSES-1:0] fresh;

  // vote token chain: slot g feeds cell g, slot NUM_CLASSES is the final verdict
  logic [NUM_CLASSES:0]   tok_valid;
  logic [NUM_CLASSES:0]   tok_found;
  logic [CLASS_W-1:0]     tok_class [NUM_CLASSES+1];
  logic [CNT_W-1:0]       tok_cnt   [NUM_CLASSES+1];
  logic [RNK_W-1:0]       tok_rank  [NUM_CLASSES+1];

  // a class is first seen in exactly one cell at most
  assign fresh_any = |fresh;

  swlv_ctrl #(
    .NUM_CLASSES  (NUM_CLASSES),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_func_i     (s_axis_tuser_i[0]),
    .s_class_i    (s_axis_tdata_i[CLASS_W-1:0]),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_has_label_o(has_label),
    .m_class_o    (voted_class),
    .upd_o        (upd),
    .fresh_i      (fresh_any),
    .vote_start_o (vote_start),
    .vote_done_i  (tok_valid[NUM_CLASSES]),
    .vote_found_i (tok_found[NUM_CLASSES]),
    .vote_class_i (tok_class[NUM_CLASSES])
  );

  // empty token enters the row at cell 0
  assign tok_valid[0] = vote_start;
  assign tok_found[0] = 1'b0;
  assign tok_class[0] = '0;
  assign tok_cnt[0]   = '0;
  assign tok_rank[0]  = '0;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
    swlv_cell #(
      .IDX  (g),
      .CNT_W(CNT_W),
      .RNK_W(RNK_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .upd_i      (upd),
      .fresh_o    (fresh[g]),
      .tok_valid_i(tok_valid[g]),
      .tok_found_i(tok_found[g]),
      .tok_class_i(tok_class[g]),
      .tok_cnt_i  (tok_cnt[g]),
      .tok_rank_i (tok_rank[g]),
      .tok_valid_o(tok_valid[g+1]),
      .tok_found_o(tok_found[g+1]),
      .tok_class_o(tok_class[g+1]),
      .tok_cnt_o  (tok_cnt[g+1]),
      .tok_rank_o (tok_rank[g+1])
    );
  end

  // pack the result item, padding to a whole byte
  assign m_axis_tdata_o = {1'b0, voted_class};
  assign m_axis_tuser_o = has_label;

endmodule

`default_nettype wire

@@ design/swlv_cell.sv @@
// one class cell: count, first-seen rank and one stage of the vote chain
`timescale 1ns / 1ps
`default_nettype none

module swlv_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6,
  parameter int unsigned RNK_W = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire swlv_pkg::cnt_upd_t           upd_i,
  output logic                              fresh_o,
  input  wire logic                         tok_valid_i,
  input  wire logic                         tok_found_i,
  input  wire logic [swlv_pkg::CLASS_W-1:0] tok_class_i,
  input  wire logic [CNT_W-1:0]             tok_cnt_i,
  input  wire logic [RNK_W-1:0]             tok_rank_i,
  output logic                              tok_valid_o,
  output logic                              tok_found_o,
  output logic [swlv_pkg::CLASS_W-1:0]      tok_class_o,
  output logic [CNT_W-1:0]                  tok_cnt_o,
  output logic [RNK_W-1:0]                  tok_rank_o
);

  import swlv_pkg::*;

  localparam logic [CLASS_W-1:0] MY_CLASS = CLASS_W'(IDX);

  logic             hit_inc;
  logic             hit_dec;
  logic             hit_seen;
  logic             better;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             seen_q;
  logic [RNK_W-1:0] rank_q;
  logic             tok_valid_q;
  logic             tok_found_q;
  logic [CLASS_W-1:0] tok_class_q;
  logic [CNT_W-1:0] tok_cnt_q;
  logic [RNK_W-1:0] tok_rank_q;

  assign hit_inc  = upd_i.inc_en  && (upd_i.inc_class  == MY_CLASS);
  assign hit_dec  = upd_i.dec_en  && (upd_i.dec_class  == MY_CLASS);
  assign hit_seen = upd_i.seen_en && (upd_i.seen_class == MY_CLASS);
  assign fresh_o  = hit_seen && !seen_q;

  always_comb begin
    count_d = count_q;
    if (hit_inc && !hit_dec) begin
      count_d = count_q + CNT_W'(1);
    end else if (hit_dec && !hit_inc && (count_q != '0)) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // higher count wins, equal count goes to the earlier first-seen class
  assign better = seen_q && (count_q != '0) &&
                  (!tok_found_i || (count_q > tok_cnt_i) ||
                   ((count_q == tok_cnt_i) && (rank_q < tok_rank_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      seen_q      <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      tok_valid_q <= tok_valid_i;
      if (fresh_o) begin
        seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fresh_o) begin
      rank_q <= upd_i.seen_rank[RNK_W-1:0];
    end
    tok_found_q <= tok_found_i || better;
    tok_class_q <= better ? MY_CLASS : tok_class_i;
    tok_cnt_q   <= better ? count_q  : tok_cnt_i;
    tok_rank_q  <= better ? rank_q   : tok_rank_i;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_found_o = tok_found_q;
  assign tok_class_o = tok_class_q;
  assign tok_cnt_o   = tok_cnt_q;
  assign tok_rank_o  = tok_rank_q;

endmodule

`default_nettype wire

@@ design/swlv_ctrl.sv @@
// sequencer: config registers, history ring and item handshakes
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_label_vote_assert.svh"

module swlv_ctrl #(
  parameter int unsigned NUM_CLASSES   = 90,
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swlv_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [swlv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            s_valid_i,
  output logic                                 s_ready_o,
  input  wire logic                            s_func_i,
  input  wire logic [swlv_pkg::CLASS_W-1:0]    s_class_i,
  output logic                                 m_valid_o,
  input  wire logic                            m_ready_i,
  output logic                                 m_has_label_o,
  output logic [swlv_pkg::CLASS_W-1:0]         m_class_o,
  output swlv_pkg::cnt_upd_t                   upd_o,
  input  wire logic                            fresh_i,
  output logic                                 vote_start_o,
  input  wire logic                            vote_done_i,
  input  wire logic                            vote_found_i,
  input  wire logic [swlv_pkg::CLASS_W-1:0]    vote_class_i
);

  import swlv_pkg::*;

  localparam int unsigned HEAD_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned LEN_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W  = LEN_W + 1;
  localparam int unsigned SEEN_W = $clog2(NUM_CLASSES + 1);
  localparam int unsigned CMP_W  = ((LEN_W > WIN_W) ? LEN_W : WIN_W) + 1;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DROP_PRE  = 3'd1;
  localparam logic [2:0] ST_APPEND    = 3'd2;
  localparam logic [2:0] ST_SETTLE    = 3'd3;
  localparam logic [2:0] ST_DROP_POST = 3'd4;
  localparam logic [2:0] ST_VSTART    = 3'd5;
  localparam logic [2:0] ST_VOTE      = 3'd6;
  localparam logic [2:0] ST_OUT       = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [HEAD_W-1:0]  head_q, head_d, head_inc;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [SEEN_W-1:0]  seen_total_q, seen_total_d;
  logic [WIN_W-1:0]   win_q;
  logic [WARM_W-1:0]  warm_q;
  logic [CLASS_W-1:0] cls_q, cls_d;
  logic               vote_q, vote_d;
  logic               has_q, has_d;
  logic [CLASS_W-1:0] res_q, res_d;
  logic [CLASS_W-1:0] rd_q;
  logic               ring_we;
  logic [SUM_W-1:0]   pos_sum;
  logic [HEAD_W-1:0]  pos;
  logic               class_ok;

  logic [CLASS_W-1:0] ring_mem [HISTORY_DEPTH];

  // write slot behind the newest entry, wrapping round the ring
  assign pos_sum  = SUM_W'(head_q) + SUM_W'(len_q);
  assign pos      = (pos_sum >= SUM_W'(HISTORY_DEPTH)) ?
                    HEAD_W'(pos_sum - SUM_W'(HISTORY_DEPTH)) : HEAD_W'(pos_sum);
  assign head_inc = (head_q == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + HEAD_W'(1);
  assign class_ok = {1'b0, s_class_i} < (CLASS_W + 1)'(NUM_CLASSES);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos] <= cls_q;
    end
    rd_q <= ring_mem[head_q];
  end

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    len_d        = len_q;
    seen_total_d = seen_total_q;
    cls_d        = cls_q;
    vote_d       = vote_q;
    has_d        = has_q;
    res_d        = res_q;
    ring_we      = 1'b0;
    vote_start_o = 1'b0;
    upd_o        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cls_d  = s_class_i;
          has_d  = 1'b0;
          res_d  = '0;
          vote_d = 1'b0;
          if (s_func_i == FUNC_EMPTY) begin
            state_d = (len_q != '0) ? ST_DROP_POST : ST_OUT;
          end else if (!class_ok) begin
            state_d = ST_OUT;
          end else begin
            upd_o.seen_en    = 1'b1;
            upd_o.seen_class = s_class_i;
            upd_o.seen_rank  = RANK_W'(seen_total_q);
            if (fresh_i) begin
              seen_total_d = seen_total_q + SEEN_W'(1);
            end
            vote_d  = CMP_W'(len_q) > CMP_W'(warm_q);
            state_d = (len_q == LEN_W'(HISTORY_DEPTH)) ? ST_DROP_PRE : ST_APPEND;
          end
        end
      end
      ST_DROP_PRE: begin
        upd_o.dec_en    = 1'b1;
        upd_o.dec_class = rd_q;
        head_d          = head_inc;
        len_d           = len_q - LEN_W'(1);
        state_d         = ST_APPEND;
      end
      ST_APPEND: begin
        ring_we         = 1'b1;
        upd_o.inc_en    = 1'b1;
        upd_o.inc_class = cls_q;
        len_d           = len_q + LEN_W'(1);
        if (!vote_q) begin
          state_d = ST_OUT;
        end else if (CMP_W'(len_q) + CMP_W'(1) > CMP_W'(win_q)) begin
          state_d = ST_SETTLE;
        end else begin
          state_d = ST_VSTART;
        end
      end
      ST_SETTLE: begin
        state_d = ST_DROP_POST;
      end
      ST_DROP_POST: begin
        upd_o.dec_en    = 1'b1;
        upd_o.dec_class = rd_q;
        head_d          = head_inc;
        len_d           = len_q - LEN_W'(1);
        state_d         = vote_q ? ST_VSTART : ST_OUT;
      end
      ST_VSTART: begin
        vote_start_o = 1'b1;
        state_d      = ST_VOTE;
      end
      ST_VOTE: begin
        if (vote_done_i) begin
          has_d   = vote_found_i;
          res_d   = vote_found_i ? vote_class_i : '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      len_q        <= '0;
      seen_total_q <= '0;
      vote_q       <= 1'b0;
      win_q        <= WINDOW_LIMIT_RST;
      warm_q       <= WARMUP_LIMIT_RST;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      len_q        <= len_d;
      seen_total_q <= seen_total_d;
      vote_q       <= vote_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_WINDOW_LIMIT: win_q  <= cfg_wdata_i;
          REG_WARMUP_LIMIT: warm_q <= cfg_wdata_i[WARM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    has_q <= has_d;
    res_q <= res_d;
  end

  assign s_ready_o     = (state_q == ST_IDLE);
  assign m_valid_o     = (state_q == ST_OUT);
  assign m_has_label_o = has_q;
  assign m_class_o     = res_q;

  `SWLV_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= LEN_W'(HISTORY_DEPTH))
  `SWLV_ASSERT(a_head_bound, clk_i, rst_ni, head_q <= HEAD_W'(HISTORY_DEPTH - 1))
  `SWLV_ASSERT(a_seen_bound, clk_i, rst_ni, seen_total_q <= SEEN_W'(NUM_CLASSES))
  `SWLV_ASSERT(a_label_range, clk_i, rst_ni, (m_valid_o && m_has_label_o) |-> ({1'b0, m_class_o} < (CLASS_W + 1)'(NUM_CLASSES)))
  `SWLV_ASSERT_NEVER(a_done_outside_vote, clk_i, rst_ni, vote_done_i && (state_q != ST_VOTE))

endmodule

`default_nettype wire

@@ tb/sv/swlv_vote_tb_pkg.sv @@
// vote tracker class: predicts voted labels and checks them in arrival order
`timescale 1ns / 1ps

package swlv_vote_tb_pkg;

  import swlv_pkg::*;

  typedef struct packed {
    logic               has_label;
    logic [CLASS_W-1:0] voted_class;
  } voted_label_t;

  class vote_tracker;

    logic [CLASS_W-1:0] ring [HISTORY_DEPTH_DEF];
    int unsigned        head;
    int unsigned        hist_len;
    int unsigned        class_hits [NUM_CLASSES_DEF];
    bit                 class_known [NUM_CLASSES_DEF];
    int unsigned        first_seen [NUM_CLASSES_DEF];
    int unsigned        known_total;
    logic [WIN_W-1:0]   window_limit;
    logic [WARM_W-1:0]  warmup_limit;

    voted_label_t       expected_labels [$];
    int unsigned        errors;
    int unsigned        n_detections;
    int unsigned        n_empties;
    int unsigned        n_voted;
    int unsigned        n_quiet;

    function new();
      head         = 0;
      hist_len     = 0;
      known_total  = 0;
      window_limit = WINDOW_LIMIT_RST;
      warmup_limit = WARMUP_LIMIT_RST;
      errors       = 0;
      n_detections = 0;
      n_empties    = 0;
      n_voted      = 0;
      n_quiet      = 0;
      foreach (class_hits[c]) begin
        class_hits[c]  = 0;
        class_known[c] = 1'b0;
        first_seen[c]  = 0;
      end
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == REG_WINDOW_LIMIT) window_limit = data[WIN_W-1:0];
      else if (addr == REG_WARMUP_LIMIT) warmup_limit = data[WARM_W-1:0];
    endfunction

    function int unsigned pending();
      return expected_labels.size();
    endfunction

    function void drop_oldest();
      int unsigned c;
      if (hist_len == 0) return;
      c = ring[head];
      if (class_hits[c] > 0) class_hits[c]--;
      head     = (head + 1) % HISTORY_DEPTH_DEF;
      hist_len = hist_len - 1;
    endfunction

    function void push_label(logic [CLASS_W-1:0] cls);
      if (hist_len >= HISTORY_DEPTH_DEF) drop_oldest();
      ring[(head + hist_len) % HISTORY_DEPTH_DEF] = cls;
      hist_len = hist_len + 1;
      class_hits[cls]++;
    endfunction

    // works out the result of one accepted item and queues it
    function void note_detection(logic func, logic [CLASS_W-1:0] cls);
      voted_label_t lbl;
      int unsigned  best_hits;
      int unsigned  best_rank;
      bit           found;
      lbl   = '0;
      found = 1'b0;
      best_hits = 0;
      best_rank = 0;
      if (func == FUNC_EMPTY) begin
        n_empties++;
        drop_oldest();
      end else if (cls < NUM_CLASSES_DEF) begin
        n_detections++;
        if (!class_known[cls]) begin
          class_known[cls] = 1'b1;
          first_seen[cls]  = known_total;
          known_total++;
        end
        if (hist_len <= warmup_limit) begin
          push_label(cls);
        end else begin
          push_label(cls);
          if (hist_len > window_limit) drop_oldest();
          for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
            if (class_known[c] && class_hits[c] != 0 &&
                (!found || class_hits[c] > best_hits ||
                 (class_hits[c] == best_hits && first_seen[c] < best_rank))) begin
              found           = 1'b1;
              lbl.voted_class = CLASS_W'(c);
              best_hits       = class_hits[c];
              best_rank       = first_seen[c];
            end
          end
          lbl.has_label = found;
        end
      end
      expected_labels.insert(expected_labels.size(), lbl);
    endfunction

    function void check_label(logic has_label, logic [CLASS_W-1:0] voted_class);
      voted_label_t exp_lbl;
      if (expected_labels.size() == 0) begin
        $error("label with no item outstanding: has_label %0d voted_class %0d",
               has_label, voted_class);
        errors++;
        return;
      end
      exp_lbl = expected_labels[0];
      expected_labels.delete(0);
      if (has_label !== exp_lbl.has_label) begin
        $error("has_label expected %0d actual %0d", exp_lbl.has_label, has_label);
        errors++;
      end
      if (voted_class !== exp_lbl.voted_class) begin
        $error("voted_class expected %0d actual %0d", exp_lbl.voted_class, voted_class);
        errors++;
      end
      if (exp_lbl.has_label) n_voted++;
      else n_quiet++;
    endfunction

  endclass

endpackage

@@ tb/sv/sliding_window_label_vote_tb.sv @@
// top level testbench of the sliding window label vote
`timescale 1ns / 1ps

module sliding_window_label_vote_tb;

  import swlv_pkg::*;
  import swlv_vote_tb_pkg::*;

  // generous bound: ~900 items plus the long hold-off
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned HOLD_CYCLES = 600;  // receiver hold-off for back-pressure
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned MAX_GAP     = 18;
  localparam int unsigned PHASE_ITEMS = 80;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_valid;
  logic [7:0]            s_data;   // [6:0] detected class, [7] zero
  logic [0:0]            s_user;   // [0] func
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic                  m_ready;
  logic [7:0]            m_axis_tdata_o;  // [6:0] voted_class, [7] zero
  logic [0:0]            m_axis_tuser_o;  // [0] has_label

  vote_tracker votes;
  int unsigned cycle_count;
  int unsigned n_settings;
  bit          gaps_on;   // both sides idle at random when set
  bit          hold_req;  // asks the receiver for one long hold-off

  sliding_window_label_vote u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // handshakes are sampled at the rising edge; results are checked before new
  // items are noted, though one item at a time means they never overlap
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (m_axis_tvalid_o && m_ready)
        votes.check_label(m_axis_tuser_o[0], m_axis_tdata_o[CLASS_W-1:0]);
      if (s_valid && s_axis_tready_o)
        votes.note_detection(s_user[0], s_data[CLASS_W-1:0]);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // receiver: per item a random stall, or one long hold-off when asked
  initial begin
    int unsigned stall;
    m_ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        m_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  // all driving tasks start and end on a falling edge
  task automatic send_item(input logic func, input logic [CLASS_W-1:0] cls);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid   = 1'b1;
    s_data    = {1'b0, cls};
    s_user[0] = func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // every item gives exactly one label, so an empty queue means the block is idle
  task automatic wait_drained();
    s_valid = 1'b0;
    while (votes.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    votes.set_reg(addr, data);
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic set_limits(input logic [WIN_W-1:0] win, input logic [WARM_W-1:0] warm);
    wait_drained();
    write_reg(REG_WINDOW_LIMIT, win);
    write_reg(REG_WARMUP_LIMIT, CFG_DATA_W'(warm));
    n_settings++;
  endtask

  // random phase: mostly labels from a small pool so that votes and ties build
  // up, with empty frames, out-of-range ids and fully random classes mixed in
  task automatic run_phase(input logic [WIN_W-1:0] win, input logic [WARM_W-1:0] warm,
                           input bit with_gaps, input bit squeeze);
    logic [CLASS_W-1:0] pool [4];
    logic [CLASS_W-1:0] cls;
    logic               func;
    int unsigned        pick;
    set_limits(win, warm);
    gaps_on = with_gaps;
    if (squeeze) hold_req = 1'b1;
    foreach (pool[i]) pool[i] = CLASS_W'($urandom_range(0, NUM_CLASSES_DEF - 1));
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      func = FUNC_LABEL;
      if (pick < 12) begin
        func = FUNC_EMPTY;
        cls  = CLASS_W'($urandom_range(0, 127));
      end else if (pick < 17) begin
        cls = CLASS_W'($urandom_range(NUM_CLASSES_DEF, 127));
      end else if (pick < 70) begin
        cls = pool[$urandom_range(0, 3)];
      end else begin
        cls = CLASS_W'($urandom_range(0, NUM_CLASSES_DEF - 1));
      end
      send_item(func, cls);
    end
  endtask

  initial begin
    votes      = new();
    n_settings = 0;
    gaps_on    = 1'b0;
    hold_req   = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    s_valid    = 1'b0;
    s_data     = '0;
    s_user     = '0;
    rst_ni     = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed, reset limits (window 30, warm-up 5)
    send_item(FUNC_EMPTY, 7'd0);    // empty frame on an empty history
    send_item(FUNC_LABEL, 7'd127);  // out of range, all ones
    send_item(FUNC_LABEL, 7'd90);   // first out-of-range id
    send_item(FUNC_LABEL, 7'd0);
    send_item(FUNC_LABEL, 7'd89);
    send_item(FUNC_LABEL, 7'd89);
    send_item(FUNC_LABEL, 7'd0);
    send_item(FUNC_LABEL, 7'd0);
    send_item(FUNC_LABEL, 7'd45);   // history of six, still warming up
    send_item(FUNC_LABEL, 7'd89);   // first vote: 0 and 89 tie, 0 seen first
    send_item(FUNC_LABEL, 7'd89);
    send_item(FUNC_EMPTY, 7'd127);  // drops the oldest 0
    send_item(FUNC_LABEL, 7'd45);
    send_item(FUNC_EMPTY, 7'd0);
    send_item(FUNC_LABEL, 7'd64);

    // zero window: every voting append drops an entry again
    set_limits(6'd0, 5'd0);
    send_item(FUNC_LABEL, 7'd3);
    send_item(FUNC_LABEL, 7'd3);
    send_item(FUNC_LABEL, 7'd4);
    send_item(FUNC_EMPTY, 7'd85);

    // window of one above a longer history: each item appends one entry and drops one
    set_limits(6'd1, 5'd0);
    send_item(FUNC_LABEL, 7'd7);
    send_item(FUNC_LABEL, 7'd42);
    send_item(FUNC_LABEL, 7'd42);

    // random phases over a spread of limits, extremes included
    run_phase(6'd32, 5'd31, 1'b1, 1'b0);  // warm-up fills the whole ring
    run_phase(6'd63, 5'd0,  1'b0, 1'b0);  // window beyond the ring depth
    run_phase(6'd1,  5'd0,  1'b1, 1'b0);
    run_phase(6'd8,  5'd3,  1'b1, 1'b1);  // receiver hold-off, sender keeps offering
    run_phase(6'd2,  5'd20, 1'b1, 1'b0);  // warm-up above window
    run_phase(6'd0,  5'd0,  1'b1, 1'b0);
    run_phase(6'd30, 5'd5,  1'b0, 1'b0);
    run_phase(6'd16, 5'd31, 1'b1, 1'b0);
    run_phase(6'd5,  5'd5,  1'b1, 1'b0);
    run_phase(6'd12, 5'd2,  1'b1, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("run: %0d detections, %0d empty frames over %0d limit settings",
             votes.n_detections, votes.n_empties, n_settings + 1);
    $display("run: %0d voted labels and %0d empty labels checked in %0d cycles",
             votes.n_voted, votes.n_quiet, cycle_count);
    if (votes.errors == 0 && votes.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
